[rtl/core/rpn_pkg.sv]
// Shared constants for the reverse Polish notation evaluator.
package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_DIVZERO   = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

endpackage

[rtl/core/rpn_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module rpn_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rpn_pkg::DATA_W-1:0] dividend,
    input  logic [rpn_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [rpn_pkg::DATA_W-1:0] quotient
);

    logic                         run_reg;
    logic                         done_reg;
    logic [rpn_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                         neg_reg;
    logic [rpn_pkg::DATA_W-1:0]   quo_reg;
    logic [rpn_pkg::DATA_W-1:0]   rem_reg;
    logic [rpn_pkg::DATA_W-1:0]   dvs_reg;
    logic [rpn_pkg::DATA_W-1:0]   mag_a;
    logic [rpn_pkg::DATA_W-1:0]   mag_b;
    logic [rpn_pkg::DATA_W:0]     rem_sh;
    logic [rpn_pkg::DATA_W:0]     diff;

    // Magnitudes; the most negative value maps to its unsigned magnitude.
    assign mag_a  = dividend[rpn_pkg::DATA_W-1] ? (~dividend + 1'b1) : dividend;
    assign mag_b  = divisor[rpn_pkg::DATA_W-1]  ? (~divisor + 1'b1)  : divisor;
    assign rem_sh = {rem_reg, quo_reg[rpn_pkg::DATA_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == rpn_pkg::DIV_CNT_W'(rpn_pkg::DATA_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag_a;
            rem_reg <= '0;
            dvs_reg <= mag_b;
            neg_reg <= dividend[rpn_pkg::DATA_W-1] ^ divisor[rpn_pkg::DATA_W-1];
        end
        else if (run_reg)
        begin
            // Restoring step: keep the difference when it does not go negative.
            if (!diff[rpn_pkg::DATA_W])
            begin
                rem_reg <= diff[rpn_pkg::DATA_W-1:0];
                quo_reg <= {quo_reg[rpn_pkg::DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[rpn_pkg::DATA_W-1:0];
                quo_reg <= {quo_reg[rpn_pkg::DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

[rtl/core/rpn_expression_evaluator.sv]
// Top level of the reverse Polish notation evaluator: stack memory and token sequencer.
//
// Usage: each input request carries one token (opcode, operand_value, last_token).
// Push tokens place operand_value on the operand stack; add, subtract, multiply
// and divide pop the two top entries (left is the deeper one) and push the result.
// On a token with last_token set, one output request carries result_value and
// status, then the stack and the sticky status clear for the next expression.
// Tokens without last_token produce no output request.
// Sequencing: push and unknown opcodes, and any token after an error, finish in
// the cycle they are taken; add, subtract and multiply go through memory read of
// the left operand, compute and write back; divide reads, runs the 32-step iterative
// divider and writes back, or skips the divider when the divisor is zero. One token
// is in work at a time; in_stall stays high until the token is done. The result of
// a last token is in the output register the cycle after the token completes.
// The top of stack lives in a register and mirrors the topmost memory entry, so
// each operator needs only one memory read.
// Reset: rst_n clears the stack count, sticky status, state and output valid; the
// stack memory itself is not cleared and needs no clearing pass.
// Output stall: the result holds in the output register while out_stall is high,
// and in_stall stays high for as long as that held result waits.
module rpn_expression_evaluator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        opcode,
    input  logic signed [rpn_pkg::DATA_W-1:0] operand_value,
    input  logic                              last_token,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [rpn_pkg::DATA_W-1:0] result_value,
    output logic [2:0]                        status
);

    typedef enum logic [3:0]
    {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [rpn_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [2:0]                   sticky_reg, sticky_next;
    logic [rpn_pkg::DATA_W-1:0]   tos_reg, tos_next;
    logic [rpn_pkg::DATA_W-1:0]   v_reg, v_next;
    logic [2:0]                   op_reg, op_next;
    logic                         last_reg, last_next;
    logic                         divz_reg, divz_next;
    logic                         out_valid_reg, out_valid_next;
    logic [rpn_pkg::DATA_W-1:0]   result_reg;
    logic [2:0]                   status_reg;

    // Stack memory: one write and one registered read port.
    logic [rpn_pkg::DATA_W-1:0]   stack_mem [rpn_pkg::STACK_DEPTH];
    logic [rpn_pkg::DATA_W-1:0]   rd_data_reg;
    logic                         mem_we;
    logic [rpn_pkg::PTR_W-1:0]    mem_waddr;
    logic [rpn_pkg::DATA_W-1:0]   mem_wdata;
    logic                         rd_en;
    logic [rpn_pkg::PTR_W-1:0]    rd_addr;

    logic                         accept;
    logic                         out_free;
    logic                         commit;
    logic                         emit;
    logic [rpn_pkg::CNT_W-1:0]    fin_count;
    logic [2:0]                   fin_sticky;
    logic [rpn_pkg::DATA_W-1:0]   fin_tos;
    logic [rpn_pkg::DATA_W-1:0]   alu_out;
    logic [rpn_pkg::CNT_W-1:0]    count_m1;
    logic [rpn_pkg::CNT_W-1:0]    count_m2;
    logic                         is_arith;

    logic                         div_start;
    logic                         div_done;
    logic [rpn_pkg::DATA_W-1:0]   div_quot;

    // The output register is free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;
    assign count_m1 = count_reg - 1'b1;
    assign count_m2 = count_reg - 2'd2;
    assign rd_addr  = count_m2[rpn_pkg::PTR_W-1:0];
    assign is_arith = (opcode == rpn_pkg::OP_ADD) || (opcode == rpn_pkg::OP_SUB) ||
                      (opcode == rpn_pkg::OP_MUL) || (opcode == rpn_pkg::OP_DIV);

    // Left operand comes from memory, right operand is the cached top.
    always_comb
    begin
        case (op_reg)
            rpn_pkg::OP_ADD: alu_out = rd_data_reg + tos_reg;
            rpn_pkg::OP_SUB: alu_out = rd_data_reg - tos_reg;
            rpn_pkg::OP_MUL: alu_out = rd_data_reg * tos_reg;
            default:         alu_out = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        op_next    = op_reg;
        last_next  = last_reg;
        divz_next  = divz_reg;
        fin_count  = count_reg;
        fin_sticky = sticky_reg;
        fin_tos    = tos_reg;
        commit     = 1'b0;
        emit       = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[rpn_pkg::PTR_W-1:0];
        mem_wdata  = operand_value;
        rd_en      = 1'b0;
        div_start  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = opcode;
                    last_next = last_token;
                    commit    = 1'b1;
                    if (sticky_reg == rpn_pkg::ST_OK)
                    begin
                        if (opcode == rpn_pkg::OP_PUSH)
                        begin
                            if (count_reg >= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH))
                            begin
                                fin_sticky = rpn_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                fin_tos   = operand_value;
                                fin_count = count_reg + 1'b1;
                            end
                        end
                        else if (is_arith)
                        begin
                            if (count_reg < rpn_pkg::CNT_W'(2))
                            begin
                                fin_sticky = rpn_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                // Fetch the left operand; finish later.
                                commit     = 1'b0;
                                rd_en      = 1'b1;
                                state_next = S_EXEC;
                            end
                        end
                    end
                    emit = commit && last_token;
                end
            end
            S_EXEC:
            begin
                divz_next = 1'b0;
                if (op_reg == rpn_pkg::OP_DIV)
                begin
                    if (tos_reg == '0)
                    begin
                        divz_next  = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    v_next     = alu_out;
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    v_next     = div_quot;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // Hold here while a result is due and the output is still occupied.
                if (!last_reg || out_free)
                begin
                    commit     = 1'b1;
                    emit       = last_reg;
                    state_next = S_IDLE;
                    if (divz_reg)
                    begin
                        fin_sticky = rpn_pkg::ST_DIVZERO;
                        fin_count  = count_m2;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = count_m2[rpn_pkg::PTR_W-1:0];
                        mem_wdata = v_reg;
                        fin_tos   = v_reg;
                        fin_count = count_m1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Apply the token effect, or drop the expression state once its result goes out.
    always_comb
    begin
        count_next  = count_reg;
        sticky_next = sticky_reg;
        tos_next    = tos_reg;
        if (commit)
        begin
            tos_next = fin_tos;
            if (emit)
            begin
                count_next  = '0;
                sticky_next = rpn_pkg::ST_OK;
            end
            else
            begin
                count_next  = fin_count;
                sticky_next = fin_sticky;
            end
        end
    end

    assign out_valid_next = emit ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sticky_reg    <= rpn_pkg::ST_OK;
            divz_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sticky_reg    <= sticky_next;
            divz_reg      <= divz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg  <= tos_next;
        v_reg    <= v_next;
        op_reg   <= op_next;
        last_reg <= last_next;
        if (emit)
        begin
            if (fin_sticky != rpn_pkg::ST_OK)
            begin
                status_reg <= fin_sticky;
                result_reg <= '0;
            end
            else if (fin_count == '0)
            begin
                status_reg <= rpn_pkg::ST_EMPTY;
                result_reg <= '0;
            end
            else
            begin
                status_reg <= rpn_pkg::ST_OK;
                result_reg <= fin_tos;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    rpn_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_data_reg),
        .divisor  (tos_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign status       = status_reg;

    // The stack count never passes the stack depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    // The divider only reports completion while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider done outside divide wait");

    // A finishing last token leaves an empty, clean stack and a pending result.
    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && last_reg && out_free) |=>
        (count_reg == '0 && sticky_reg == rpn_pkg::ST_OK && out_valid_reg))
        else $error("expression state not cleared after result");

    // After an error, tokens never start memory work.
    a_sticky_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sticky_reg != rpn_pkg::ST_OK) |=> (state_reg == S_IDLE))
        else $error("token processed after sticky error");

endmodule

[tb/tb_rpn_expression_evaluator.sv]
// Self-checking testbench for the reverse Polish notation evaluator.
`timescale 1ns / 100ps

module tb_rpn_expression_evaluator;

    // Opcodes above divide are not operators; the block must treat them as no-ops.
    localparam logic [2:0] OP_BAD_LO = 3'd5;
    localparam logic [2:0] OP_BAD_HI = 3'd7;

    localparam logic [rpn_pkg::DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [rpn_pkg::DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [rpn_pkg::DATA_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

    localparam int RANDOM_TOKENS = 950;
    // Keep the last stretch of tokens free of idle and stall bursts.
    localparam int TAIL_LEN      = 100;
    // Drain wait after the last result; covers a divide through the divider and output reg.
    localparam int DRAIN_CYCLES  = 80;
    // Worst case about 1000 tokens, each a divide with an idle and a stall burst; allow ~8x that.
    localparam int TIMEOUT_NS    = 5_000_000;

    typedef struct {
        logic [2:0]                 op;
        logic [rpn_pkg::DATA_W-1:0] val;
        logic                       last;
    } token_t;

    typedef struct {
        logic [rpn_pkg::DATA_W-1:0] value;
        logic [2:0]                 code;
    } result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [2:0]        opcode = rpn_pkg::OP_PUSH;
    logic signed [rpn_pkg::DATA_W-1:0] operand_value = '0;
    logic              last_token = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic signed [rpn_pkg::DATA_W-1:0] result_value;
    logic [2:0]        status;

    // Set at each rising edge when the input request was taken.
    logic              tok_accepted = 1'b0;

    token_t  token_q[$];
    result_t due_results[$];
    int      mismatch_count = 0;
    int      in_gap = 0;
    int      stall_gap = 0;

    // Shadow copy of the block's stack, fill level and sticky error.
    logic [rpn_pkg::DATA_W-1:0] calc_stack [rpn_pkg::STACK_DEPTH];
    int                calc_depth = 0;
    logic [2:0]        calc_error = rpn_pkg::ST_OK;

    rpn_expression_evaluator dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .operand_value(operand_value),
        .last_token   (last_token),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .status       (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Divide with truncation toward zero; most negative / -1 wraps to itself.
    function automatic logic [rpn_pkg::DATA_W-1:0] trunc_quotient(
        input logic [rpn_pkg::DATA_W-1:0] l,
        input logic [rpn_pkg::DATA_W-1:0] r);
        logic [rpn_pkg::DATA_W-1:0] ma;
        logic [rpn_pkg::DATA_W-1:0] mb;
        logic [rpn_pkg::DATA_W-1:0] q;
        ma = l[rpn_pkg::DATA_W-1] ? (~l + 1'b1) : l;
        mb = r[rpn_pkg::DATA_W-1] ? (~r + 1'b1) : r;
        q  = ma / mb;
        return (l[rpn_pkg::DATA_W-1] ^ r[rpn_pkg::DATA_W-1]) ? (~q + 1'b1) : q;
    endfunction

    // Apply one accepted token to the shadow stack; queue a result on the last one.
    task automatic evaluate_token(input logic [2:0] op,
                                  input logic [rpn_pkg::DATA_W-1:0] val,
                                  input logic last);
        logic [rpn_pkg::DATA_W-1:0] l;
        logic [rpn_pkg::DATA_W-1:0] r;
        logic [rpn_pkg::DATA_W-1:0] v;
        result_t res;
        if (calc_error == rpn_pkg::ST_OK)
        begin
            if (op == rpn_pkg::OP_PUSH)
            begin
                if (calc_depth >= rpn_pkg::STACK_DEPTH)
                    calc_error = rpn_pkg::ST_OVERFLOW;
                else
                begin
                    calc_stack[calc_depth] = val;
                    calc_depth++;
                end
            end
            else if (op <= rpn_pkg::OP_DIV)
            begin
                if (calc_depth < 2)
                    calc_error = rpn_pkg::ST_UNDERFLOW;
                else
                begin
                    r = calc_stack[calc_depth-1];
                    l = calc_stack[calc_depth-2];
                    calc_depth -= 2;
                    case (op)
                        rpn_pkg::OP_ADD: v = l + r;
                        rpn_pkg::OP_SUB: v = l - r;
                        rpn_pkg::OP_MUL: v = l * r;
                        default:         v = (r == '0) ? '0 : trunc_quotient(l, r);
                    endcase
                    // Divide by zero pops both operands and pushes nothing.
                    if (op == rpn_pkg::OP_DIV && r == '0)
                        calc_error = rpn_pkg::ST_DIVZERO;
                    else
                    begin
                        calc_stack[calc_depth] = v;
                        calc_depth++;
                    end
                end
            end
        end
        if (last)
        begin
            res.value = '0;
            res.code  = calc_error;
            if (calc_error == rpn_pkg::ST_OK)
            begin
                if (calc_depth == 0)
                    res.code = rpn_pkg::ST_EMPTY;
                else
                    res.value = calc_stack[calc_depth-1];
            end
            due_results.push_back(res);
            calc_depth = 0;
            calc_error = rpn_pkg::ST_OK;
        end
    endtask

    task automatic add_token(input logic [2:0] op, input logic [rpn_pkg::DATA_W-1:0] val,
                             input logic last);
        token_t tok;
        tok.op   = op;
        tok.val  = val;
        tok.last = last;
        token_q.push_back(tok);
    endtask

    // Favor corner values so wraps, zero divisors and the min / -1 case show up.
    function automatic logic [rpn_pkg::DATA_W-1:0] rand_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2:       return VAL_NEG1;
            3:       return VAL_MIN;
            4:       return VAL_MAX;
            5, 6:    return rpn_pkg::DATA_W'($signed($urandom_range(0, 40)) - 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return rpn_pkg::OP_ADD;
            1:       return rpn_pkg::OP_SUB;
            2:       return rpn_pkg::OP_MUL;
            default: return rpn_pkg::OP_DIV;
        endcase
    endfunction

    // Build one expression and append it to the token queue, last flag on its final token.
    task automatic gen_expression();
        token_t expr_q[$];
        token_t tok;
        int     kind;
        int     pushes;
        int     depth;
        kind  = $urandom_range(0, 15);
        depth = 0;
        tok.last = 1'b0;
        if (kind == 0)
        begin
            // Deep expression: fill to around the stack depth, then fold it down.
            pushes = $urandom_range(rpn_pkg::STACK_DEPTH - 4, rpn_pkg::STACK_DEPTH + 4);
            repeat (pushes)
            begin
                tok.op  = rpn_pkg::OP_PUSH;
                tok.val = rand_operand();
                expr_q.push_back(tok);
            end
            repeat (pushes - 1)
            begin
                tok.op  = pick_operator();
                tok.val = $urandom;
                expr_q.push_back(tok);
            end
        end
        else if (kind == 1)
        begin
            // Pure noise: any opcode, unknown ones included.
            repeat ($urandom_range(1, 10))
            begin
                tok.op  = 3'($urandom);
                tok.val = rand_operand();
                expr_q.push_back(tok);
            end
        end
        else
        begin
            pushes = $urandom_range(1, 8);
            while (pushes > 0 || depth > 1)
            begin
                if (pushes > 0 && (depth < 2 || $urandom_range(0, 1) == 0))
                begin
                    tok.op  = rpn_pkg::OP_PUSH;
                    tok.val = rand_operand();
                    pushes--;
                    depth++;
                end
                else
                begin
                    tok.op  = pick_operator();
                    tok.val = $urandom;
                    depth--;
                end
                expr_q.push_back(tok);
                // Sprinkle stray tokens into some expressions to break them.
                if (kind == 3 && $urandom_range(0, 7) == 0)
                begin
                    tok.op  = 3'($urandom);
                    tok.val = rand_operand();
                    expr_q.push_back(tok);
                end
                // Leave entries behind now and then.
                if (kind == 2 && pushes == 0 && $urandom_range(0, 2) == 0)
                    break;
            end
        end
        tok = expr_q.pop_back();
        tok.last = 1'b1;
        expr_q.push_back(tok);
        foreach (expr_q[i])
            token_q.push_back(expr_q[i]);
    endtask

    // Input driver: present the next request at the falling edge; hold it until taken.
    always @(negedge clk)
    begin : drive_tokens
        token_t tok;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && !tok_accepted))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (token_q.size() > TAIL_LEN && $urandom_range(0, 5) == 0)
            begin
                // Start an idle burst, this cycle counting as its first.
                in_gap = $urandom_range(0, 10);
                in_valid <= 1'b0;
            end
            else if (token_q.size() > 0)
            begin
                tok = token_q.pop_front();
                in_valid      <= 1'b1;
                opcode        <= tok.op;
                operand_value <= tok.val;
                last_token    <= tok.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output stall: random bursts, none in the tail.
    always @(negedge clk)
    begin
        if (stall_gap > 0)
        begin
            stall_gap--;
            out_stall <= 1'b1;
        end
        else if (token_q.size() > TAIL_LEN && $urandom_range(0, 5) == 0)
        begin
            stall_gap = $urandom_range(0, 10);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Monitor: at each rising edge check a taken result, then predict from a taken token.
    // Check first: a result leaving now can never belong to the token taken at this edge.
    always @(posedge clk)
    begin : watch_ports
        result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                    report_mismatch($sformatf("unexpected result value=%0d status=%0d",
                                              result_value, status));
                else
                begin
                    want = due_results.pop_front();
                    if (result_value !== want.value)
                        report_mismatch($sformatf("result_value got %0d want %0d",
                                                  result_value, $signed(want.value)));
                    if (status !== want.code)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  status, want.code));
                end
            end
            if (in_valid && !in_stall)
                evaluate_token(opcode, operand_value, last_token);
        end
        tok_accepted <= rst_n && in_valid && !in_stall;
    end

    // Stimulus and end of run.
    initial
    begin
        // Directed: wrap on add, min / -1, truncation toward zero.
        add_token(rpn_pkg::OP_PUSH, VAL_MAX, 1'b0);
        add_token(rpn_pkg::OP_PUSH, 32'd1, 1'b0);
        add_token(rpn_pkg::OP_ADD, $urandom, 1'b1);
        add_token(rpn_pkg::OP_PUSH, VAL_MIN, 1'b0);
        add_token(rpn_pkg::OP_PUSH, VAL_NEG1, 1'b0);
        add_token(rpn_pkg::OP_DIV, $urandom, 1'b1);
        add_token(rpn_pkg::OP_PUSH, -32'sd7, 1'b0);
        add_token(rpn_pkg::OP_PUSH, 32'd2, 1'b0);
        add_token(rpn_pkg::OP_DIV, $urandom, 1'b1);
        // Subtract order and multiply.
        add_token(rpn_pkg::OP_PUSH, 32'd5, 1'b0);
        add_token(rpn_pkg::OP_PUSH, 32'd3, 1'b0);
        add_token(rpn_pkg::OP_SUB, $urandom, 1'b0);
        add_token(rpn_pkg::OP_PUSH, 32'd6, 1'b0);
        add_token(rpn_pkg::OP_MUL, $urandom, 1'b1);
        // Divide by zero, then tokens that must be ignored until the end.
        add_token(rpn_pkg::OP_PUSH, 32'd1, 1'b0);
        add_token(rpn_pkg::OP_PUSH, 32'd0, 1'b0);
        add_token(rpn_pkg::OP_DIV, $urandom, 1'b0);
        add_token(rpn_pkg::OP_PUSH, 32'd5, 1'b0);
        add_token(rpn_pkg::OP_MUL, $urandom, 1'b1);
        // Underflow on an empty stack.
        add_token(rpn_pkg::OP_ADD, $urandom, 1'b1);
        // Leftover entries: report the top, last flag on a push.
        add_token(rpn_pkg::OP_PUSH, 32'd3, 1'b0);
        add_token(rpn_pkg::OP_PUSH, 32'd4, 1'b1);
        // Unknown opcode as the only token: empty end.
        add_token(OP_BAD_HI, $urandom, 1'b1);
        // Unknown opcode leaves the stack alone.
        add_token(rpn_pkg::OP_PUSH, 32'd9, 1'b0);
        add_token(OP_BAD_LO, $urandom, 1'b1);

        while (token_q.size() < 25 + RANDOM_TOKENS)
            gen_expression();

        // Hold reset, then release it at a falling edge, away from the rising edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every token to go in, then for every result to come out.
        while (token_q.size() > 0 || in_valid)
            @(posedge clk);
        while (due_results.size() > 0)
            @(posedge clk);
        // Catch any stray result from a token still in work.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("** rpn_expression_evaluator: PASSED **");
        else
            $display("** rpn_expression_evaluator: FAILED **");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d tokens and %0d results outstanding",
                 token_q.size(), due_results.size());
        $display("** rpn_expression_evaluator: FAILED **");
        $finish;
    end

endmodule
